// ----- rtl/frequency_sweep_generator_defines.svh -----
// Assertion macros for the file that carries concurrent checks.
`ifndef FREQUENCY_SWEEP_GENERATOR_DEFINES_SVH
`define FREQUENCY_SWEEP_GENERATOR_DEFINES_SVH

`ifndef SYNTH
`define FSG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define FSG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FSG_ASSERT_IMP(lbl, ante, cons, msg)
`define FSG_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/fsg_pkg.sv -----
package fsg_pkg;

  localparam int FREQ_W     = 35;
  localparam int FIN_W      = 27;
  localparam int PERIOD_W   = 32;
  localparam int CYCLE_W    = 33;
  localparam int REPS_W     = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int LOG_FRAC   = 24;
  localparam int UNIT_SHIFT = 30;
  localparam int MANT_W     = 31;
  localparam int EXP_W      = 5;
  localparam int LOG_W      = EXP_W + LOG_FRAC;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;
  localparam int QCNT_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_START_FREQ   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_FREQ    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOG_MODE     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UP_DOWN      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENDLESS      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REPETITIONS  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 4'd7;

  typedef struct packed {
    logic [FIN_W-1:0]    start_freq;
    logic [FIN_W-1:0]    stop_freq;
    logic [PERIOD_W-1:0] period_ticks;
    logic                log_mode;
    logic                up_down;
    logic                endless;
    logic [REPS_W-1:0]   repetitions;
    logic                enable;
  } cfg_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] phase;
    logic                fin;
    logic                inv;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CALC,
    BK_MUL,
    BK_EXP,
    BK_VMUL,
    BK_SCALE
  } back_state_t;

  function automatic logic [FIN_W-1:0] nz_freq(input logic [FIN_W-1:0] f);
    return (f == '0) ? FIN_W'(1) : f;
  endfunction

  function automatic logic [PERIOD_W-1:0] nz_period(input logic [PERIOD_W-1:0] p);
    return (p == '0) ? PERIOD_W'(1) : p;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    v   = val;
    res = '0;
    bt  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bt > v) bt = bt >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bt != '0) begin
        if (v >= res + bt) begin
          v   = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // Root k is 2^(2^-k) in units of 2^30, built by repeated square roots.
  function automatic logic [63:0] root_val(input int k);
    logic [63:0] r;
    r = 64'd1 << (UNIT_SHIFT + 1);
    for (int j = 1; j <= LOG_FRAC; j++) begin
      if (j <= k) r = isqrt64(r << UNIT_SHIFT);
    end
    return r;
  endfunction

endpackage

// ----- rtl/fsg_in_if.sv -----
interface fsg_in_if;
  logic valid;
  logic ready;
  logic action;
  logic paused;
  modport source (output valid, output action, output paused, input ready);
  modport sink (input valid, input action, input paused, output ready);
endinterface

// ----- rtl/fsg_out_if.sv -----
interface fsg_out_if;
  logic                       valid;
  logic                       ready;
  logic [fsg_pkg::FREQ_W-1:0] frequency;
  logic                       finished;
  modport source (output valid, output frequency, output finished, input ready);
  modport sink (input valid, input frequency, input finished, output ready);
endinterface

// ----- rtl/fsg_queue.sv -----
module fsg_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fsg_pkg::job_t push_data,
  input  logic          pop,
  output fsg_pkg::job_t pop_data,
  output logic          full,
  output logic          empty
);

  fsg_pkg::job_t                      slot_r [fsg_pkg::QDEPTH];
  logic [fsg_pkg::QPTR_W-1:0]         wr_ptr_r;
  logic [fsg_pkg::QPTR_W-1:0]         rd_ptr_r;
  logic [fsg_pkg::QCNT_W-1:0]         cnt_r;

  assign full     = (cnt_r == fsg_pkg::QCNT_W'(fsg_pkg::QDEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

// ----- rtl/fsg_front.sv -----
module fsg_front (
  input  logic                              clk,
  input  logic                              rst_n,
  fsg_in_if.sink                            in_ch,
  input  logic                              cfg_we,
  input  logic [fsg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fsg_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              q_full,
  output logic                              q_push,
  output fsg_pkg::job_t                     q_job,
  output fsg_pkg::cfg_t                     cfg
);

  fsg_pkg::cfg_t                     cfg_r, cfg_nxt;
  logic [fsg_pkg::PERIOD_W-1:0]      phase_r, phase_nxt;
  logic [fsg_pkg::CYCLE_W-1:0]       cycle_r, cycle_nxt;
  logic                              exh_r, exh_nxt;
  logic                              cfg_restart;
  logic                              accept;
  logic                              emit_ok;
  logic                              fin;
  logic                              inv;
  logic [fsg_pkg::CYCLE_W-1:0]       total;
  logic [fsg_pkg::PERIOD_W:0]        phase_inc;
  logic [fsg_pkg::PERIOD_W-1:0]      per;
  logic [fsg_pkg::FIN_W-1:0]         fa, fb;

  assign cfg         = cfg_r;
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign per       = fsg_pkg::nz_period(cfg_r.period_ticks);
  assign fa        = fsg_pkg::nz_freq(cfg_r.start_freq);
  assign fb        = fsg_pkg::nz_freq(cfg_r.stop_freq);
  assign emit_ok   = cfg_r.enable && !(!cfg_r.endless && exh_r);
  assign total     = cfg_r.up_down ? {cfg_r.repetitions, 1'b0} : {1'b0, cfg_r.repetitions};
  assign fin       = !cfg_r.endless && (cycle_r >= total);
  assign inv       = (fa > fb) ^ (cycle_r[0] && cfg_r.up_down);
  assign phase_inc = {1'b0, phase_r} + 1'b1;

  assign q_push = accept && !in_ch.action && !in_ch.paused && emit_ok;
  assign q_job  = '{phase: phase_r, fin: fin, inv: inv};

  // Changes restart the sweep (reps only if not endless); same values do not.
  always_comb begin
    cfg_nxt     = cfg_r;
    cfg_restart = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        fsg_pkg::REG_START_FREQ: begin
          cfg_nxt.start_freq = cfg_data[fsg_pkg::FIN_W-1:0];
          cfg_restart        = cfg_nxt.start_freq != cfg_r.start_freq;
        end
        fsg_pkg::REG_STOP_FREQ: begin
          cfg_nxt.stop_freq = cfg_data[fsg_pkg::FIN_W-1:0];
          cfg_restart       = cfg_nxt.stop_freq != cfg_r.stop_freq;
        end
        fsg_pkg::REG_PERIOD_TICKS: begin
          cfg_nxt.period_ticks = cfg_data[fsg_pkg::PERIOD_W-1:0];
          cfg_restart          = cfg_nxt.period_ticks != cfg_r.period_ticks;
        end
        fsg_pkg::REG_LOG_MODE: begin
          cfg_nxt.log_mode = cfg_data[0];
          cfg_restart      = cfg_nxt.log_mode != cfg_r.log_mode;
        end
        fsg_pkg::REG_UP_DOWN: begin
          cfg_nxt.up_down = cfg_data[0];
          cfg_restart     = cfg_nxt.up_down != cfg_r.up_down;
        end
        fsg_pkg::REG_ENDLESS: begin
          cfg_nxt.endless = cfg_data[0];
          cfg_restart     = cfg_nxt.endless != cfg_r.endless;
        end
        fsg_pkg::REG_REPETITIONS: begin
          cfg_nxt.repetitions = cfg_data[fsg_pkg::REPS_W-1:0];
          cfg_restart = (cfg_nxt.repetitions != cfg_r.repetitions) && !cfg_r.endless;
        end
        fsg_pkg::REG_ENABLE: begin
          cfg_nxt.enable = cfg_data[0];
          cfg_restart    = cfg_nxt.enable != cfg_r.enable;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    cycle_nxt = cycle_r;
    exh_nxt   = exh_r;
    if (cfg_restart) begin
      phase_nxt = '0;
      cycle_nxt = '0;
      exh_nxt   = (cfg_nxt.repetitions == '0);
    end else if (accept) begin
      if (in_ch.action) begin
        phase_nxt = '0;
        cycle_nxt = '0;
        exh_nxt   = (cfg_r.repetitions == '0);
      end else if (!in_ch.paused) begin
        if (emit_ok && fin) exh_nxt = 1'b1;
        if (phase_inc >= {1'b0, per}) begin
          phase_nxt = '0;
          cycle_nxt = cycle_r + 1'b1;
        end else begin
          phase_nxt = phase_inc[fsg_pkg::PERIOD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{start_freq: 27'd1000, stop_freq: 27'd1000, period_ticks: 32'd1000,
                 log_mode: 1'b0, up_down: 1'b0, endless: 1'b1,
                 repetitions: '0, enable: 1'b0};
      phase_r <= '0;
      cycle_r <= '0;
      exh_r   <= 1'b0;
    end else begin
      cfg_r   <= cfg_nxt;
      phase_r <= phase_nxt;
      cycle_r <= cycle_nxt;
      exh_r   <= exh_nxt;
    end
  end

endmodule

// ----- rtl/fsg_log2.sv -----
module fsg_log2 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [fsg_pkg::FIN_W-1:0]     v,
  output logic                          busy,
  output logic [fsg_pkg::LOG_W-1:0]     result
);

  logic [fsg_pkg::MANT_W-1:0]     m_r;
  logic [fsg_pkg::LOG_FRAC-1:0]   frac_r;
  logic [fsg_pkg::EXP_W-1:0]      e_r;
  logic [fsg_pkg::EXP_W-1:0]      cnt_r;
  logic                           busy_r;
  logic [fsg_pkg::EXP_W-1:0]      e_init;
  logic [fsg_pkg::MANT_W-1:0]     m_init;
  logic [2*fsg_pkg::MANT_W-1:0]   sq;
  logic [fsg_pkg::MANT_W:0]       m2;

  assign busy   = busy_r;
  assign result = {e_r, frac_r};

  always_comb begin
    e_init = '0;
    for (int i = 0; i < fsg_pkg::FIN_W; i++) begin
      if (v[i]) e_init = fsg_pkg::EXP_W'(i);
    end
  end

  assign m_init = fsg_pkg::MANT_W'(v) << (fsg_pkg::EXP_W'(fsg_pkg::UNIT_SHIFT) - e_init);

  // Squaring the mantissa doubles the log; a carry past two yields the next bit.
  assign sq = m_r * m_r;
  assign m2 = sq[fsg_pkg::UNIT_SHIFT +: fsg_pkg::MANT_W + 1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= fsg_pkg::EXP_W'(fsg_pkg::LOG_FRAC);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == fsg_pkg::EXP_W'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m_r    <= m_init;
      e_r    <= e_init;
      frac_r <= '0;
    end else if (busy_r) begin
      frac_r <= {frac_r[fsg_pkg::LOG_FRAC-2:0], m2[fsg_pkg::MANT_W]};
      m_r    <= m2[fsg_pkg::MANT_W] ? m2[fsg_pkg::MANT_W:1] : m2[fsg_pkg::MANT_W-1:0];
    end
  end

endmodule

// ----- rtl/fsg_back.sv -----
module fsg_back #(
  parameter int FF = 8,
  parameter int XF = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  fsg_pkg::cfg_t cfg,
  input  logic          job_valid,
  input  fsg_pkg::job_t job,
  output logic          pop,
  fsg_out_if.source     out_ch
);

  localparam int XQ_W    = XF + 1;
  localparam int DCNT_W  = $clog2(XF + 1);
  localparam int PROD_W  = fsg_pkg::LOG_W + XQ_W;
  localparam int Y_W     = PROD_W - XF;
  localparam int N_W     = Y_W - fsg_pkg::LOG_FRAC;
  localparam int V_W     = fsg_pkg::FIN_W + fsg_pkg::MANT_W;
  localparam int VS_W    = V_W + FF;
  localparam int SH_W    = 8;
  localparam int SUM_W   = fsg_pkg::FIN_W + FF + 2;
  localparam int KW      = fsg_pkg::EXP_W;
  localparam logic [XQ_W-1:0] X_ONE = XQ_W'(1) << XF;
  localparam logic [fsg_pkg::MANT_W-1:0] P_ONE = fsg_pkg::MANT_W'(1) << fsg_pkg::UNIT_SHIFT;

  fsg_pkg::back_state_t             state_r, state_nxt;
  logic                             fin_r, inv_r, sat_r;
  logic [fsg_pkg::PERIOD_W-1:0]     rem_r;
  logic [XF-1:0]                    quo_r;
  logic [DCNT_W-1:0]                dcnt_r;
  logic [XQ_W-1:0]                  xq_r;
  logic [PROD_W-1:0]                prod_r;
  logic [fsg_pkg::MANT_W-1:0]       p_r;
  logic [KW-1:0]                    k_r;
  logic [V_W-1:0]                   v_r;
  logic                             out_valid_r;
  logic [fsg_pkg::FREQ_W-1:0]       out_freq_r;
  logic                             out_fin_r;

  logic [fsg_pkg::FIN_W-1:0]        fa, fb, lo, hi;
  logic [fsg_pkg::PERIOD_W-1:0]     per;
  logic [fsg_pkg::PERIOD_W:0]       rem_sh;
  logic                             q_bit;
  logic [XQ_W-1:0]                  xq_base, xq_sel;
  logic                             busy_hi, busy_lo;
  logic [fsg_pkg::LOG_W-1:0]        log_hi, log_lo, span, mul_a;
  logic [Y_W-1:0]                   y;
  logic [N_W-1:0]                   n;
  logic [fsg_pkg::LOG_FRAC-1:0]     f;
  logic [KW-1:0]                    fidx;
  logic [fsg_pkg::MANT_W-1:0]       root_tab [2**KW];
  logic [2*fsg_pkg::MANT_W-1:0]     pm;
  logic [SH_W-1:0]                  nf;
  logic [VS_W-1:0]                  v_ext, vs, top;
  logic [SUM_W-1:0]                 lin_sum;
  logic [XF+FF-1:0]                 r_ext;
  logic [fsg_pkg::FREQ_W-1:0]       res;
  logic                             out_free, out_load, log_done;

  for (genvar g = 0; g < 2**KW; g++) begin : g_root
    localparam logic [63:0] RV = (g >= 1 && g <= fsg_pkg::LOG_FRAC) ? fsg_pkg::root_val(g) : '0;
    assign root_tab[g] = RV[fsg_pkg::MANT_W-1:0];
  end

  assign fa  = fsg_pkg::nz_freq(cfg.start_freq);
  assign fb  = fsg_pkg::nz_freq(cfg.stop_freq);
  assign lo  = (fa < fb) ? fa : fb;
  assign hi  = (fa < fb) ? fb : fa;
  assign per = fsg_pkg::nz_period(cfg.period_ticks);

  fsg_log2 u_log_hi (.clk, .rst_n, .start(pop), .v(hi), .busy(busy_hi), .result(log_hi));
  fsg_log2 u_log_lo (.clk, .rst_n, .start(pop), .v(lo), .busy(busy_lo), .result(log_lo));

  // Restoring division of phase by period, one fraction bit per cycle.
  assign rem_sh  = {rem_r, 1'b0};
  assign q_bit   = rem_sh >= {1'b0, per};
  assign xq_base = fin_r ? (cfg.up_down ? '0 : X_ONE) : (sat_r ? X_ONE : {1'b0, quo_r});
  assign xq_sel  = inv_r ? X_ONE - xq_base : xq_base;

  assign span  = log_hi - log_lo;
  assign mul_a = cfg.log_mode ? span : fsg_pkg::LOG_W'(hi - lo);
  assign y     = prod_r[PROD_W-1:XF];
  assign n     = y[Y_W-1:fsg_pkg::LOG_FRAC];
  assign f     = y[fsg_pkg::LOG_FRAC-1:0];
  assign fidx  = KW'(fsg_pkg::LOG_FRAC) - k_r;
  assign pm    = p_r * root_tab[k_r];

  // Log result: lo * 2^n * p scaled to the output fraction, clamped at hi.
  assign nf    = SH_W'(n) + SH_W'(FF);
  assign v_ext = VS_W'(v_r);
  assign vs    = (nf >= SH_W'(fsg_pkg::UNIT_SHIFT)) ? v_ext << (nf - SH_W'(fsg_pkg::UNIT_SHIFT))
                                                    : v_ext >> (SH_W'(fsg_pkg::UNIT_SHIFT) - nf);
  assign top   = VS_W'(hi) << FF;

  assign r_ext   = {prod_r[XF-1:0], FF'(0)};
  assign lin_sum = (SUM_W'(lo) << FF) + (SUM_W'(prod_r[PROD_W-1:XF]) << FF) + SUM_W'(r_ext >> XF);
  assign res     = cfg.log_mode ? fsg_pkg::FREQ_W'((vs > top) ? top : vs)
                                : fsg_pkg::FREQ_W'(lin_sum);

  assign log_done = !cfg.log_mode || (!busy_hi && !busy_lo);
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = (state_r == fsg_pkg::BK_SCALE) && out_free;
  assign pop      = (state_r == fsg_pkg::BK_IDLE) && job_valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fsg_pkg::BK_IDLE:  if (job_valid) state_nxt = fsg_pkg::BK_CALC;
      fsg_pkg::BK_CALC:  if (dcnt_r == '0 && log_done) state_nxt = fsg_pkg::BK_MUL;
      fsg_pkg::BK_MUL:   state_nxt = cfg.log_mode ? fsg_pkg::BK_EXP : fsg_pkg::BK_SCALE;
      fsg_pkg::BK_EXP:   if (k_r == KW'(fsg_pkg::LOG_FRAC)) state_nxt = fsg_pkg::BK_VMUL;
      fsg_pkg::BK_VMUL:  state_nxt = fsg_pkg::BK_SCALE;
      fsg_pkg::BK_SCALE: if (out_free) state_nxt = fsg_pkg::BK_IDLE;
      default:           state_nxt = fsg_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsg_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      fsg_pkg::BK_IDLE: if (job_valid) begin
        fin_r  <= job.fin;
        inv_r  <= job.inv;
        sat_r  <= job.phase >= per;
        rem_r  <= job.phase;
        quo_r  <= '0;
        dcnt_r <= DCNT_W'(XF);
      end
      fsg_pkg::BK_CALC: begin
        if (dcnt_r != '0) begin
          rem_r  <= q_bit ? fsg_pkg::PERIOD_W'(rem_sh - {1'b0, per})
                          : rem_sh[fsg_pkg::PERIOD_W-1:0];
          quo_r  <= {quo_r[XF-2:0], q_bit};
          dcnt_r <= dcnt_r - 1'b1;
        end
        xq_r <= xq_sel;
      end
      fsg_pkg::BK_MUL: begin
        prod_r <= mul_a * xq_r;
        p_r    <= P_ONE;
        k_r    <= KW'(1);
      end
      fsg_pkg::BK_EXP: begin
        if (f[fidx]) p_r <= pm[fsg_pkg::UNIT_SHIFT +: fsg_pkg::MANT_W];
        k_r <= k_r + 1'b1;
      end
      fsg_pkg::BK_VMUL: v_r <= lo * p_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_freq_r <= res;
      out_fin_r  <= fin_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.frequency = out_freq_r;
  assign out_ch.finished  = out_fin_r;

endmodule

// ----- rtl/frequency_sweep_generator.sv -----
// Channel   Dir   Beat payload
// in_ch     in    action (tick or restart), paused
// out_ch    out   frequency (Hz, FREQ_FRAC_BITS fraction), finished
// cfg_*     in    write enable, register index, 32-bit data
//
// The front takes one input beat per cycle while its two-entry job queue has room;
// restarts and paused ticks finish there and push no job.
// In linear mode a frequency passes the restoring division, a multiply and the scaling; log
// mode also waits for the 24-step log2 squaring loop and runs the 24-step exp2 root product.
// Reset is synchronous on rst_n and loads the register defaults; no clearing pass.
// The output register holds a beat under backpressure while the back works on.
`include "frequency_sweep_generator_defines.svh"

module frequency_sweep_generator #(
  parameter int FREQ_FRAC_BITS = 8,
  parameter int X_FRAC_BITS    = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fsg_in_if.sink                          in_ch,
  fsg_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [fsg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fsg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  fsg_pkg::cfg_t cfg;
  fsg_pkg::job_t push_job, pop_job;
  logic          q_push, q_pop, q_full, q_empty;

  fsg_front u_front (
    .clk, .rst_n, .in_ch, .cfg_we, .cfg_index, .cfg_data,
    .q_full, .q_push, .q_job(push_job), .cfg
  );

  fsg_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_data(push_job), .pop(q_pop),
    .pop_data(pop_job), .full(q_full), .empty(q_empty)
  );

  fsg_back #(.FF(FREQ_FRAC_BITS), .XF(X_FRAC_BITS)) u_back (
    .clk, .rst_n, .cfg, .job_valid(!q_empty), .job(pop_job), .pop(q_pop), .out_ch
  );

  `FSG_ASSERT_IMP(a_no_overflow, q_push, !q_full, "job pushed into a full queue")
  `FSG_ASSERT_IMP(a_no_underflow, q_pop, !q_empty, "job popped from an empty queue")
  `FSG_ASSERT_NXT(a_full_blocks, q_full && !q_pop, !q_push, "push right after a full queue")

endmodule

// ----- tb/fsg_sweep_checker.sv -----
module fsg_sweep_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  fsg_in_if                               in_ch,
  fsg_out_if                              out_ch,
  input  logic                            cfg_we,
  input  logic [fsg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fsg_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              pending,
  output int                              fail_count,
  output int                              freq_beats
);
  import fsg_pkg::*;

  localparam int FFB = 8;
  localparam int XFB = 16;
  localparam logic [63:0] X_ONE = 64'd1 << XFB;

  typedef struct packed {
    logic [FREQ_W-1:0] frequency;
    logic              finished;
  } sweep_beat_t;

  sweep_beat_t expected_beats[$];
  logic [63:0] root_tab[0:LOG_FRAC];

  // Shadow of the register file and the sweep clock.
  logic [FIN_W-1:0]    r_start, r_stop;
  logic [PERIOD_W-1:0] r_period;
  logic                r_log, r_updown, r_endless, r_enable;
  logic [REPS_W-1:0]   r_reps;
  logic [63:0]         phase_ticks, sweep_cycles;
  logic                run_over;
  int                  errors;

  assign pending    = expected_beats.size();
  assign fail_count = errors + expected_beats.size();

  function automatic logic [63:0] sqrt_floor(input logic [63:0] val);
    logic [63:0] v, acc, b;
    v = val;
    acc = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= acc + b) begin
        v = v - (acc + b);
        acc = (acc >> 1) + b;
      end else begin
        acc = acc >> 1;
      end
      b = b >> 2;
    end
    return acc;
  endfunction

  initial begin
    root_tab[0] = 64'd1 << (UNIT_SHIFT + 1);
    for (int k = 1; k <= LOG_FRAC; k++) root_tab[k] = sqrt_floor(root_tab[k-1] << UNIT_SHIFT);
  end

  function automatic logic [63:0] log2_q24(input logic [63:0] v);
    logic [63:0] e, m, frac;
    e = 0;
    frac = 0;
    while (e < 40 && (v >> (e + 1)) != 0) e++;
    m = v << (UNIT_SHIFT - e);
    for (int i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> UNIT_SHIFT;
      frac = frac << 1;
      if (m >= (64'd1 << (UNIT_SHIFT + 1))) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return (e << LOG_FRAC) | frac;
  endfunction

  function automatic logic [63:0] log_freq(input logic [63:0] lo, hi, xq);
    logic [63:0] y, n, f, p, v, top;
    int sh;
    y = ((log2_q24(hi) - log2_q24(lo)) * xq) >> XFB;
    n = y >> LOG_FRAC;
    f = y & ((64'd1 << LOG_FRAC) - 1);
    p = 64'd1 << UNIT_SHIFT;
    for (int k = 1; k <= LOG_FRAC; k++)
      if ((f >> (LOG_FRAC - k)) & 1) p = (p * root_tab[k]) >> UNIT_SHIFT;
    v = lo * p;
    sh = int'(n) + FFB - UNIT_SHIFT;
    if (sh >= 0) v = v << sh;
    else v = v >> (-sh);
    top = hi << FFB;
    return (v > top) ? top : v;
  endfunction

  function automatic logic [63:0] lin_freq(input logic [63:0] lo, hi, xq);
    logic [63:0] prod;
    prod = (hi - lo) * xq;
    return (lo << FFB) + ((prod >> XFB) << FFB) +
           (((prod & ((64'd1 << XFB) - 1)) << FFB) >> XFB);
  endfunction

  task automatic restart_sweep();
    phase_ticks = 0;
    sweep_cycles = 0;
    run_over = (r_reps == 0);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
    logic changed;
    changed = 0;
    case (idx)
      REG_START_FREQ: begin changed = (r_start != d[26:0]); r_start = d[26:0]; end
      REG_STOP_FREQ: begin changed = (r_stop != d[26:0]); r_stop = d[26:0]; end
      REG_PERIOD_TICKS: begin changed = (r_period != d); r_period = d; end
      REG_LOG_MODE: begin changed = (r_log != d[0]); r_log = d[0]; end
      REG_UP_DOWN: begin changed = (r_updown != d[0]); r_updown = d[0]; end
      REG_ENDLESS: begin changed = (r_endless != d[0]); r_endless = d[0]; end
      REG_REPETITIONS: begin
        changed = (r_reps != d) && !r_endless;
        r_reps = d;
      end
      REG_ENABLE: begin changed = (r_enable != d[0]); r_enable = d[0]; end
      default: ;
    endcase
    if (changed) restart_sweep();
  endtask

  task automatic sweep_tick(input logic action, input logic paused);
    logic [63:0] per, a, b, lo, hi, xq, total, freq;
    logic fin;
    per = (r_period == 0) ? 64'd1 : 64'(r_period);
    a = (r_start == 0) ? 64'd1 : 64'(r_start);
    b = (r_stop == 0) ? 64'd1 : 64'(r_stop);
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    fin = 0;
    if (action) begin
      restart_sweep();
      return;
    end
    if (paused) return;
    if (r_enable && !(!r_endless && run_over)) begin
      xq = (phase_ticks << XFB) / per;
      if (xq > X_ONE) xq = X_ONE;
      if (!r_endless) begin
        total = 64'(r_reps) * (r_updown ? 2 : 1);
        if (sweep_cycles >= total) begin
          run_over = 1;
          fin = 1;
          xq = r_updown ? 0 : X_ONE;
        end
      end
      if (a > b) xq = X_ONE - xq;
      if (sweep_cycles[0] && r_updown) xq = X_ONE - xq;
      freq = r_log ? log_freq(lo, hi, xq) : lin_freq(lo, hi, xq);
      expected_beats.push_back('{frequency: freq[FREQ_W-1:0], finished: fin});
    end
    phase_ticks++;
    if (phase_ticks >= per) begin
      phase_ticks = 0;
      sweep_cycles = (sweep_cycles + 1) & 64'h1_FFFF_FFFF;
    end
  endtask

  always @(posedge clk) begin
    sweep_beat_t want;
    if (!rst_n) begin
      r_start = 1000;
      r_stop = 1000;
      r_period = 1000;
      r_log = 0;
      r_updown = 0;
      r_endless = 1;
      r_reps = 0;
      r_enable = 0;
      phase_ticks = 0;
      sweep_cycles = 0;
      run_over = 0;
      errors = 0;
      freq_beats = 0;
      expected_beats.delete();
    end else begin
      if (cfg_we) write_register(cfg_index, cfg_data);
      if (in_ch.valid && in_ch.ready) sweep_tick(in_ch.action, in_ch.paused);
      if (out_ch.valid && out_ch.ready) begin
        freq_beats++;
        if (expected_beats.size() == 0) begin
          $error("frequency beat with nothing expected: frequency %0d finished %0b",
                 out_ch.frequency, out_ch.finished);
          errors++;
        end else begin
          want = expected_beats.pop_front();
          if (want.frequency !== out_ch.frequency) begin
            $error("frequency: expected %0d, got %0d", want.frequency, out_ch.frequency);
            errors++;
          end
          if (want.finished !== out_ch.finished) begin
            $error("finished: expected %0b, got %0b", want.finished, out_ch.finished);
            errors++;
          end
        end
      end
    end
  end
endmodule

// ----- tb/frequency_sweep_generator_tb.sv -----
module frequency_sweep_generator_tb;
  import fsg_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE = 200;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int pending, fail_count, freq_beats;
  int items_sent = 0;
  int settings_run = 0;
  int stall_cycles = 0;
  bit quiet = 0;
  bit hold_req = 0;

  fsg_in_if in_ch();
  fsg_out_if out_ch();

  initial begin
    in_ch.valid = 0;
    in_ch.action = 0;
    in_ch.paused = 0;
    out_ch.ready = 0;
  end

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  frequency_sweep_generator DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fsg_sweep_checker sweep_check (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .fail_count(fail_count), .freq_beats(freq_beats)
  );

  // Receiver: random stalls, one long hold-off on request, none at the end.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && rst_n && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_beat(input logic action, input logic paused);
    in_ch.valid <= 1;
    in_ch.action <= action;
    in_ch.paused <= paused;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register writes happen only while no input beat is offered.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
    in_ch.valid <= 0;
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_freq();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return 1;
      2: return 125000000;
      3: return 32'h07FF_FFFF;
      4: return $urandom;
      default: return $urandom_range(1, 125000000);
    endcase
  endfunction

  function automatic logic [31:0] pick_period();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return 32'hFFFF_FFFF;
      3: return $urandom;
      default: return $urandom_range(2, 24);
    endcase
  endfunction

  task automatic program_sweep(input logic [31:0] f0, f1, per, input logic lg, ud, en,
                               input logic [31:0] reps);
    write_reg(REG_START_FREQ, f0);
    write_reg(REG_STOP_FREQ, f1);
    write_reg(REG_PERIOD_TICKS, per);
    write_reg(REG_LOG_MODE, lg);
    write_reg(REG_UP_DOWN, ud);
    write_reg(REG_ENDLESS, en);
    write_reg(REG_REPETITIONS, reps);
    write_reg(REG_ENABLE, 1);
    cfg_we <= 0;
    @(posedge clk);
    settings_run++;
  endtask

  initial begin
    logic [31:0] reps;
    logic act, pau;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Disabled after reset: ticks are taken but nothing comes out.
    send_beat(0, 0);
    send_beat(0, 1);
    send_beat(1, 0);
    drain();
    program_sweep(1, 125000000, 4, 0, 0, 1, 0);
    for (int i = 0; i < 5; i++) send_beat(0, 0);
    send_beat(0, 1);
    send_beat(1, 1);
    drain();
    program_sweep(125000000, 1, 3, 1, 1, 0, 1);
    for (int i = 0; i < 9; i++) send_beat(0, 0);
    drain();
    program_sweep(0, 32'hFFFF_FFFF, 0, 1, 0, 0, 0);
    send_beat(1, 0);
    send_beat(0, 0);
    write_reg(4'd9, 32'hFFFF_FFFF);
    write_reg(REG_ENABLE, 0);
    cfg_we <= 0;
    @(posedge clk);
    send_beat(0, 0);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      quiet = (ph >= 10);
      case ($urandom_range(0, 3))
        0: reps = 0;
        1: reps = 32'hFFFF_FFFF;
        default: reps = $urandom_range(1, 3);
      endcase
      program_sweep(pick_freq(), pick_freq(), pick_period(), $urandom_range(0, 1),
                    $urandom_range(0, 1), $urandom_range(0, 2) == 0, reps);
      if (ph == 3) hold_req = 1;
      for (int i = 0; i < 30; i++) begin
        act = ($urandom_range(0, 24) == 0);
        pau = ($urandom_range(0, 6) == 0);
        send_beat(act, pau);
      end
      drain();
    end

    $display("covered %0d input beats and %0d frequency beats over %0d register settings",
             items_sent, freq_beats, settings_run);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
